// ----- src/ckb_pkg.sv -----
// ----------------------------------------------------------------------------
// ckb_pkg: shared types and constants for the color-key sprite blitter
// Command and result codes, transfer payloads, register map, store request.
// ----------------------------------------------------------------------------
package ckb_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // store address / row product width (covers 64 x 256 entries)
  localparam int SADDR_W = 14;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  // signed offset width for move arithmetic
  localparam int OFS_W   = 18;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_DRAW = 2'd1,
    CMD_MOVE = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KEY    = 3'd2,
    REG_SHADOW = 3'd3,
    REG_CLEAR  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [5:0]         src_row;
    logic [5:0]         src_col;
    logic [15:0]        pixel_value;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic               shadow_mode;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [15:0]        color;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  w_eff;
    logic [6:0]  h_eff;
    logic [15:0] key_color;
    logic [15:0] shadow_color;
    logic [15:0] clear_color;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [SADDR_W-1:0] waddr;
    logic [15:0]        wdata;
    logic               re;
    logic [SADDR_W-1:0] raddr_a;
    logic [SADDR_W-1:0] raddr_b;
  } mem_req_t;

endpackage

// ----- src/ckb_cfg.sv -----
// ----------------------------------------------------------------------------
// ckb_cfg: configuration register file
// APB-style slave holding sprite size and colors; size clamped to maximum.
// ----------------------------------------------------------------------------
module ckb_cfg #(
  parameter int MAX_WIDTH  = ckb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ckb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ckb_pkg::CFG_AW-1:0] paddr,
  input  logic [ckb_pkg::CFG_DW-1:0] pwdata,
  output logic [ckb_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output ckb_pkg::cfg_t              cfg
);
  import ckb_pkg::*;

  logic [6:0]  width_r;
  logic [6:0]  height_r;
  logic [15:0] key_r;
  logic [15:0] shadow_r;
  logic [15:0] clear_r;
  reg_idx_t    idx;
  logic        wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      key_r    <= '0;
      shadow_r <= '0;
      clear_r  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  width_r  <= pwdata[6:0];
        REG_HEIGHT: height_r <= pwdata[6:0];
        REG_KEY:    key_r    <= pwdata[15:0];
        REG_SHADOW: shadow_r <= pwdata[15:0];
        REG_CLEAR:  clear_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = {25'd0, width_r};
      REG_HEIGHT: prdata = {25'd0, height_r};
      REG_KEY:    prdata = {16'd0, key_r};
      REG_SHADOW: prdata = {16'd0, shadow_r};
      REG_CLEAR:  prdata = {16'd0, clear_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg.w_eff = (width_r > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_r;
  assign cfg.h_eff = ({2'b00, height_r} > 9'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_r;
  assign cfg.key_color    = key_r;
  assign cfg.shadow_color = shadow_r;
  assign cfg.clear_color  = clear_r;

endmodule

// ----- src/ckb_store.sv -----
// ----------------------------------------------------------------------------
// ckb_store: sprite pixel memory
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module ckb_store #(
  parameter int DEPTH = ckb_pkg::DEF_MAX_WIDTH * ckb_pkg::DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  ckb_pkg::mem_req_t req,
  output logic [15:0]       rdata_a,
  output logic [15:0]       rdata_b
);
  import ckb_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_a_r;
  logic [15:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata_a_r <= mem[req.raddr_a[ADDR_W-1:0]];
      rdata_b_r <= mem[req.raddr_b[ADDR_W-1:0]];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- src/ckb_engine.sv -----
// ----------------------------------------------------------------------------
// ckb_engine: command sequencer
// Shared row multiplier, store clearing sweep, column scan with a one-deep
// read stage, a pending-write holder for the last flag, and the output register.
// ----------------------------------------------------------------------------
module ckb_engine #(
  parameter int DEPTH = ckb_pkg::DEF_MAX_WIDTH * ckb_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ckb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ckb_pkg::out_item_t out_data,
  input  ckb_pkg::cfg_t      cfg,
  output ckb_pkg::mem_req_t  mem_req,
  input  logic [15:0]        rdata_a,
  input  logic [15:0]        rdata_b
);
  import ckb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MUL_ROW, S_MUL_AUX, S_ACCESS, S_RDATA, S_SCAN, S_FINISH
  } state_t;

  localparam out_item_t ACK_ITEM = '{kind: KIND_ACK, screen_x: '0, screen_y: '0,
                                     color: '0, last: 1'b1};

  state_t             state_r, state_nxt;
  in_item_t           cmd_r, cmd_nxt;
  logic [OFS_W-1:0]   nr_r, nr_nxt;
  logic [OFS_W-1:0]   nc_r, nc_nxt;
  logic [15:0]        x_r, x_nxt;
  logic [15:0]        y_r, y_nxt;
  logic [SADDR_W-1:0] row_base_r, row_base_nxt;
  logic [SADDR_W-1:0] nrow_base_r, nrow_base_nxt;
  logic [SADDR_W-1:0] total_r, total_nxt;
  logic               nr_ok_r, nr_ok_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [6:0]         col_r, col_nxt;
  logic               s1_v_r, s1_v_nxt;
  logic [15:0]        s1_x_r, s1_x_nxt;
  logic               s1_newok_r, s1_newok_nxt;
  logic               pend_v_r, pend_v_nxt;
  out_item_t          pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic [SADDR_W-1:0] clr_r, clr_nxt;

  logic [6:0]         mul_a;
  logic [SADDR_W-1:0] prod;
  logic [SADDR_W-1:0] acc_addr;
  logic               acc_ok;
  logic               out_free;
  logic               col_lt;
  logic               nc_ok;
  logic               is_move;
  logic [15:0]        nv;
  logic               emit;
  logic [15:0]        emit_color;
  logic               s1_fire;
  logic               iss;
  logic               push;
  out_item_t          push_data;

  // shared multiplier: row base, new-row base, store extent
  always_comb begin
    unique case (state_r)
      S_MUL_ROW: mul_a = {1'b0, cmd_r.src_row};
      S_MUL_AUX: mul_a = (cmd_r.cmd == CMD_MOVE) ? nr_r[6:0] : cfg.h_eff;
      default:   mul_a = '0;
    endcase
  end
  assign prod = {7'd0, mul_a} * {7'd0, cfg.w_eff};

  assign acc_addr = row_base_r + SADDR_W'(cmd_r.src_col);
  assign acc_ok   = acc_addr < total_r;
  assign out_free = !out_valid_r || !out_stall;
  assign col_lt   = col_r < cfg.w_eff;
  assign nc_ok    = !nc_r[OFS_W-1] && (nc_r < OFS_W'(cfg.w_eff));
  assign is_move  = (cmd_r.cmd == CMD_MOVE);

  assign nv   = s1_newok_r ? rdata_b : cfg.key_color;
  assign emit = (rdata_a != cfg.key_color) && (!is_move || nv == cfg.key_color);
  assign emit_color = is_move ? cfg.clear_color :
                      (cmd_r.shadow_mode ? cfg.shadow_color : rdata_a);

  assign s1_fire = s1_v_r && (!emit || !pend_v_r || out_free);
  assign iss     = (state_r == S_SCAN) && col_lt && (!s1_v_r || s1_fire);

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    nr_nxt        = nr_r;
    nc_nxt        = nc_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    row_base_nxt  = row_base_r;
    nrow_base_nxt = nrow_base_r;
    total_nxt     = total_r;
    nr_ok_nxt     = nr_ok_r;
    rd_ok_nxt     = rd_ok_r;
    col_nxt       = col_r;
    s1_v_nxt      = s1_v_r;
    s1_x_nxt      = s1_x_r;
    s1_newok_nxt  = s1_newok_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    clr_nxt       = clr_r;
    push          = 1'b0;
    push_data     = ACK_ITEM;

    mem_req.we      = 1'b0;
    mem_req.waddr   = acc_addr;
    mem_req.wdata   = cmd_r.pixel_value;
    mem_req.re      = 1'b0;
    mem_req.raddr_a = acc_addr;
    mem_req.raddr_b = nrow_base_r + SADDR_W'(nc_r[6:0]);

    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = '0;
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == SADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data;
          nr_nxt    = {12'd0, in_data.src_row}
                      - {{2{in_data.to_y[15]}}, in_data.to_y}
                      + {{2{in_data.from_y[15]}}, in_data.from_y};
          nc_nxt    = {{2{in_data.from_x[15]}}, in_data.from_x}
                      - {{2{in_data.to_x[15]}}, in_data.to_x};
          x_nxt     = in_data.from_x;
          y_nxt     = in_data.from_y + {10'd0, in_data.src_row};
          state_nxt = S_MUL_ROW;
        end
      end

      S_MUL_ROW: begin
        row_base_nxt = prod;
        state_nxt    = S_MUL_AUX;
      end

      S_MUL_AUX: begin
        col_nxt = '0;
        case (cmd_r.cmd) inside
          CMD_LOAD, CMD_READ: begin
            total_nxt = prod;
            state_nxt = S_ACCESS;
          end
          default: begin
            nrow_base_nxt = prod;
            nr_ok_nxt     = !nr_r[OFS_W-1] && (nr_r < OFS_W'(cfg.h_eff));
            state_nxt     = ({1'b0, cmd_r.src_row} >= cfg.h_eff) ? S_FINISH : S_SCAN;
          end
        endcase
      end

      S_ACCESS: begin
        if (cmd_r.cmd == CMD_READ) begin
          mem_req.re = 1'b1;
          rd_ok_nxt  = acc_ok;
          state_nxt  = S_RDATA;
        end else if (out_free) begin
          mem_req.we = acc_ok;
          push       = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_RDATA: begin
        if (out_free) begin
          push            = 1'b1;
          push_data.kind  = KIND_READ;
          push_data.color = rd_ok_r ? rdata_a : 16'd0;
          state_nxt       = S_IDLE;
        end
      end

      S_SCAN: begin
        mem_req.re      = iss;
        mem_req.raddr_a = row_base_r + SADDR_W'(col_r);
        if (iss) begin
          col_nxt      = col_r + 1'b1;
          nc_nxt       = nc_r + 1'b1;
          x_nxt        = x_r + 1'b1;
          s1_x_nxt     = x_r;
          s1_newok_nxt = nc_ok && nr_ok_r && is_move;
        end
        if (s1_fire && emit) begin
          push       = pend_v_r;
          push_data  = pend_r;
          pend_v_nxt = 1'b1;
          pend_nxt   = '{kind: KIND_WRITE, screen_x: s1_x_r, screen_y: y_r,
                         color: emit_color, last: 1'b0};
        end
        s1_v_nxt = iss ? 1'b1 : (s1_fire ? 1'b0 : s1_v_r);
        if (!col_lt && !s1_v_r) begin
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          push = 1'b1;
          if (pend_v_r) begin
            push_data      = pend_r;
            push_data.last = 1'b1;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = push ? 1'b1 : (out_valid_r && out_stall);
    out_data_nxt  = push ? push_data : out_data_r;
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    nr_r        <= nr_nxt;
    nc_r        <= nc_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    row_base_r  <= row_base_nxt;
    nrow_base_r <= nrow_base_nxt;
    total_r     <= total_nxt;
    nr_ok_r     <= nr_ok_nxt;
    rd_ok_r     <= rd_ok_nxt;
    col_r       <= col_nxt;
    s1_x_r      <= s1_x_nxt;
    s1_newok_r  <= s1_newok_nxt;
    pend_r      <= pend_nxt;
    out_data_r  <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      s1_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      s1_v_r      <= s1_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/color_key_sprite_blitter.sv -----
// ----------------------------------------------------------------------------
// color_key_sprite_blitter: color-key sprite blitter, top level
// A 16-bit sprite store with load, read, draw-row and move-clear-row commands.
//
// Commands arrive on the in_ channel (valid/stall); results leave on the out_
// channel, one transfer per result, last set on the final result of a command.
// Sizes and colors are set through the cfg_ APB-style port, by the user only while idle; the block does not enforce it.
// One command at a time: in_stall stays high from acceptance until the
// sequencer has handed its final result to the output register.
// Load steps through the row multiply, the extent multiply and the store write;
// read adds a read-data step. Draw or move row scans the columns, one store
// read per column through the shared row-address multiplier and a single read stage.
// Each screen write is held in a pending register so that the last flag can be set; when
// the receiver stalls the scan pauses and the output register holds its value.
// After reset the store is swept to zero, one entry per cycle, over all
// MAX_WIDTH*MAX_HEIGHT entries (4096 by default) with in_stall high.
// ----------------------------------------------------------------------------
module color_key_sprite_blitter #(
  parameter int MAX_WIDTH  = ckb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ckb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ckb_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ckb_pkg::out_item_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ckb_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ckb_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ckb_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import ckb_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  cfg_t        cfg;
  mem_req_t    mem_req;
  logic [15:0] rdata_a;
  logic [15:0] rdata_b;

  ckb_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .cfg    (cfg)
  );

  ckb_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .req    (mem_req),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  ckb_engine #(
    .DEPTH(DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg      (cfg),
    .mem_req  (mem_req),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b)
  );

endmodule

// ----- src/ckb_checker.sv -----
// ----------------------------------------------------------------------------
// ckb_checker: port-level checks for the sprite blitter
// Busy after acceptance, clearing after reset, output hold, last on singles.
// ----------------------------------------------------------------------------
module ckb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ckb_pkg::out_item_t out_data
);
  import ckb_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a transfer on consecutive cycles");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("input open before store clear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != KIND_WRITE) |-> out_data.last)
    else $error("acknowledge or read data without last");

endmodule

bind color_key_sprite_blitter ckb_checker u_ckb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ----- bench/blit_check_pkg.sv -----
// ----------------------------------------------------------------------------
// blit_check_pkg: result checking for the color-key sprite blitter bench
// Keeps its own sprite store and register copies, works out the results of
// each accepted command and compares them in order with the block's output.
// ----------------------------------------------------------------------------
package blit_check_pkg;

  import ckb_pkg::*;

  class blit_scoreboard;
    logic [15:0] sprite [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
    int          width_reg;
    int          height_reg;
    logic [15:0] key_c;
    logic [15:0] shadow_c;
    logic [15:0] clear_c;
    out_item_t   due_q[$];
    int          errors;

    function new();
      foreach (sprite[i]) sprite[i] = '0;
      width_reg  = 0;
      height_reg = 0;
      key_c      = '0;
      shadow_c   = '0;
      clear_c    = '0;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_WIDTH:  width_reg  = int'(v[6:0]);
        REG_HEIGHT: height_reg = int'(v[6:0]);
        REG_KEY:    key_c      = v[15:0];
        REG_SHADOW: shadow_c   = v[15:0];
        REG_CLEAR:  clear_c    = v[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function out_item_t screen_write(int x, int y, logic [15:0] color);
      out_item_t o;
      o          = '0;
      o.kind     = KIND_WRITE;
      o.screen_x = x[15:0];
      o.screen_y = y[15:0];
      o.color    = color;
      return o;
    endfunction

    // expected results of one accepted command; updates the store on loads
    function void note_command(in_item_t it);
      out_item_t   batch[$];
      out_item_t   o;
      int          w, h, row, col, addr, fx, fy, dx, dy, nr, nc, c;
      logic [15:0] old_px, new_px;
      w    = (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
      h    = (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
      row  = int'(it.src_row);
      col  = int'(it.src_col);
      addr = row * w + col;
      fx   = int'($signed(it.from_x));
      fy   = int'($signed(it.from_y));
      dx   = int'($signed(it.to_x)) - fx;
      dy   = int'($signed(it.to_y)) - fy;
      nr   = row - dy;
      case (it.cmd)
        CMD_LOAD: begin
          if (addr < w * h) sprite[addr] = it.pixel_value;
        end
        CMD_READ: begin
          o       = '0;
          o.kind  = KIND_READ;
          o.color = (addr < w * h) ? sprite[addr] : 16'h0000;
          batch.push_back(o);
        end
        default: begin
          if (row < h) begin
            for (c = 0; c < w; c++) begin
              old_px = sprite[row * w + c];
              if (it.cmd == CMD_DRAW) begin
                if (old_px != key_c)
                  batch.push_back(screen_write(fx + c, fy + row,
                                               it.shadow_mode ? shadow_c : old_px));
              end else begin
                nc     = c - dx;
                new_px = key_c;
                if (nc >= 0 && nc < w && nr >= 0 && nr < h)
                  new_px = sprite[nr * w + nc];
                if (old_px != key_c && new_px == key_c)
                  batch.push_back(screen_write(fx + c, fy + row, clear_c));
              end
            end
          end
        end
      endcase
      if (batch.size() == 0) begin
        o      = '0;
        o.kind = KIND_ACK;
        batch.push_back(o);
      end
      o                       = batch[batch.size()-1];
      o.last                  = 1'b1;
      batch[batch.size()-1]   = o;
      foreach (batch[i]) due_q.push_back(batch[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (due_q.size() == 0) begin
        $error("unexpected result: kind %0d x %0d y %0d color %h last %b",
               got.kind, got.screen_x, got.screen_y, got.color, got.last);
        errors++;
        return;
      end
      e = due_q.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, got.kind);
        errors++;
      end
      if (got.screen_x !== e.screen_x) begin
        $error("screen_x: expected %0d, got %0d", e.screen_x, got.screen_x);
        errors++;
      end
      if (got.screen_y !== e.screen_y) begin
        $error("screen_y: expected %0d, got %0d", e.screen_y, got.screen_y);
        errors++;
      end
      if (got.color !== e.color) begin
        $error("color: expected %h, got %h", e.color, got.color);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %b, got %b", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- bench/color_key_sprite_blitter_tb.sv -----
// ----------------------------------------------------------------------------
// color_key_sprite_blitter_tb: self-checking bench for the sprite blitter
// Directed loads, reads, draws and moves at the edges of the sprite and of
// the screen, then random command streams over several sprite sizes and
// colors, with bursty input, a stalling receiver and one long output hold.
// ----------------------------------------------------------------------------
module color_key_sprite_blitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckb_pkg::*;
  import blit_check_pkg::*;

  localparam int RUN_LIMIT   = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 50;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  blit_scoreboard sb = new();
  int cycle_count = 0;

  color_key_sprite_blitter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("color_key_sprite_blitter_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_data);
  end

  // receiver: changing stall patterns, plus one long hold once traffic runs
  initial begin
    int mode, left, seen_in;
    bit held;
    out_stall = 1'b0;
    mode      = 0;
    left      = 0;
    seen_in   = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0) seen_in++;
      if (!held && seen_in >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(99) < 30);
          2: out_stall <= (left % 3 == 0);
          default: out_stall <= ($urandom_range(99) < 70);
        endcase
      end
    end
  end

  function automatic in_item_t make_cmd(cmd_t c, int row, int col, int pix,
                                        int fx, int fy, int tx, int ty, bit sh);
    in_item_t it;
    it.cmd         = c;
    it.src_row     = row[5:0];
    it.src_col     = col[5:0];
    it.pixel_value = pix[15:0];
    it.from_x      = fx[15:0];
    it.from_y      = fy[15:0];
    it.to_x        = tx[15:0];
    it.to_y        = ty[15:0];
    it.shadow_mode = sh;
    return it;
  endfunction

  function automatic in_item_t random_cmd(int w, int h, logic [15:0] key);
    int pick, row, col, pix, fx, fy, tx, ty;
    pick = $urandom_range(99);
    row  = (h > 0 && $urandom_range(9) < 8) ? $urandom_range(h - 1) : $urandom_range(63);
    col  = (w > 0 && $urandom_range(9) < 8) ? $urandom_range(w - 1) : $urandom_range(63);
    case ($urandom_range(9))
      0, 1, 2, 3: pix = int'(key);
      4:          pix = 0;
      5:          pix = 16'hFFFF;
      default:    pix = $urandom;
    endcase
    fx = ($urandom_range(3) == 0) ? int'($urandom_range(40)) - 20 : $urandom;
    fy = ($urandom_range(3) == 0) ? int'($urandom_range(40)) - 20 : $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        tx = fx + int'($urandom_range(6)) - 3;
        ty = fy + int'($urandom_range(6)) - 3;
      end
      6, 7: begin
        tx = fx;
        ty = fy;
      end
      default: begin
        tx = $urandom;
        ty = $urandom;
      end
    endcase
    return make_cmd(pick < 40 ? CMD_LOAD : pick < 65 ? CMD_DRAW : pick < 85 ? CMD_MOVE
                    : CMD_READ, row, col, pix, fx, fy, tx, ty, $urandom_range(1));
  endfunction

  task automatic send_item(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_command(it);
  endtask

  // drop valid and wait until every expected result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_settings(int w, int h, logic [15:0] key,
                                logic [15:0] shadow, logic [15:0] clear_c);
    settle();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_KEY, key);
    cfg_write(REG_SHADOW, shadow);
    cfg_write(REG_CLEAR, clear_c);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int w, int h, logic [15:0] key, logic [15:0] shadow,
                           logic [15:0] clear_c, int n);
    int burst, k, gap;
    apply_settings(w, h, key, shadow, clear_c);
    burst = 0;
    for (k = 0; k < n; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_item(random_cmd(w, h, key));
      burst--;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);

    // empty sprite: loads drop, reads return zero, draws and moves acknowledge
    apply_settings(0, 0, 16'h0000, 16'h0000, 16'h0000);
    send_item(make_cmd(CMD_LOAD, 0, 0, 16'h1234, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0, 1));
    send_item(make_cmd(CMD_MOVE, 0, 0, 0, 0, 0, 3, 3, 0));

    apply_settings(8, 4, 16'hF81F, 16'h1234, 16'hFFFF);
    send_item(make_cmd(CMD_LOAD, 0, 0, 16'hF81F, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_LOAD, 0, 1, 16'hFFFF, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_LOAD, 0, 2, 16'h0000, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_LOAD, 0, 3, 16'hF81F, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_LOAD, 0, 4, 16'h8000, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_LOAD, 0, 5, 16'h0001, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_LOAD, 0, 6, 16'hF81F, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_LOAD, 0, 7, 16'h7FFF, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_LOAD, 3, 7, 16'hABCD, 0, 0, 0, 0, 0));
    // past the end of the sprite: dropped
    send_item(make_cmd(CMD_LOAD, 3, 8, 16'h1111, 0, 0, 0, 0, 0));
    // column beyond width spills into a later row
    send_item(make_cmd(CMD_LOAD, 1, 9, 16'h2222, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_READ, 0, 1, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_READ, 3, 8, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_READ, 2, 1, 0, 0, 0, 0, 0, 0));
    // screen coordinates wrap
    send_item(make_cmd(CMD_DRAW, 0, 0, 0, 32767, -32768, 0, 0, 0));
    send_item(make_cmd(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0, 1));
    send_item(make_cmd(CMD_DRAW, 5, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_MOVE, 0, 0, 0, 0, 0, 1, 0, 0));
    // offsets past 16 bits move the whole sprite away
    send_item(make_cmd(CMD_MOVE, 0, 0, 0, -32768, -32768, 32767, 32767, 0));
    send_item(make_cmd(CMD_MOVE, 0, 0, 0, 5, 5, 5, 5, 0));
    send_item(make_cmd(CMD_MOVE, 9, 0, 0, 0, 0, 2, 2, 0));

    run_phase(8, 8, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
              $urandom_range(16'hFFFF), 60);
    run_phase(64, 64, 16'h0000, 16'hFFFF, 16'h0000, 40);
    run_phase(1, 1, 16'hFFFF, 16'h0000, 16'hFFFF, 20);
    run_phase(64, 1, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
              $urandom_range(16'hFFFF), 30);
    run_phase(1, 64, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
              $urandom_range(16'hFFFF), 20);
    run_phase($urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(16'hFFFF),
              $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), 40);
    run_phase(3, 5, 16'h0000, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), 30);

    settle();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("color_key_sprite_blitter_tb: PASS");
    else
      $display("color_key_sprite_blitter_tb: FAIL");
    $finish;
  end

endmodule

// ----- color_key_sprite_blitter.f -----
src/ckb_pkg.sv
src/ckb_cfg.sv
src/ckb_store.sv
src/ckb_engine.sv
src/color_key_sprite_blitter.sv
src/ckb_checker.sv
bench/blit_check_pkg.sv
bench/color_key_sprite_blitter_tb.sv
